FILE: rtl/clfp_pkg.sv
// shared constants and types for the cursor list free pool
`default_nettype none
package clfp_pkg;

  localparam int CAPACITY    = 32;
  localparam int MAX_RESULTS = 32;
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int SLOT_W      = 6;
  localparam int LINK_W      = 7;
  localparam int CNT_W       = 7;

  // link word: top bit set means null
  localparam logic [LINK_W-1:0] NIL = 7'h40;

  typedef enum logic [3:0] {
    ACT_INS_END  = 4'd0,
    ACT_INS_HEAD = 4'd1,
    ACT_INS_POS  = 4'd2,
    ACT_DEL_END  = 4'd3,
    ACT_DEL_HEAD = 4'd4,
    ACT_DEL_POS  = 4'd5,
    ACT_DEL_ONE  = 4'd6,
    ACT_DEL_ALL  = 4'd7,
    ACT_READ     = 4'd8
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

endpackage
`default_nettype wire

FILE: rtl/cursor_list_free_pool.sv
// cursor list free pool: linked list of values in a node store with a free chain
//
// One action is taken on in_ when in_valid and in_ready are high; in_ready is
// high only while no action is in progress. Each action gives one transfer on
// out_, except read, which gives one transfer per element (at most MAX_RESULTS),
// with out_last on the final one.
// Inserts and deletes walk the chain from the head to their position; match
// deletes scan the list up to the first match (delete one) or to its end (delete
// all), freeing each matching node. The walk takes one hop of the chain at a
// time, bounded by the link memory's one read per cycle. A read streams one
// element per cycle while the receiver takes them.
// Results sit in an output register: a new action is accepted while the last
// result still waits. When the receiver stalls, the block holds in its
// result step until the register frees up, and state does not change.
// Reset (synchronous, rst_n low) empties the list and chains all slots into the
// free pool; link entries read their reset pattern until first written, so no
// clearing pass is needed.
`default_nettype none
module cursor_list_free_pool (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [3:0]                  in_action,
  input  wire logic signed [31:0]          in_value,
  input  wire logic [6:0]                  in_position,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       out_status,
  output logic signed [31:0]               out_element,
  output logic [clfp_pkg::SLOT_W-1:0]      out_slot,
  output logic [clfp_pkg::CNT_W-1:0]       out_length,
  output logic                             out_last
);
  import clfp_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_POP   = 12'b000000000010,
    S_WALK  = 12'b000000000100,
    S_INS_A = 12'b000000001000,
    S_INS_B = 12'b000000010000,
    S_DEL_A = 12'b000000100000,
    S_DEL_B = 12'b000001000000,
    S_SCAN  = 12'b000010000000,
    S_SC_A  = 12'b000100000000,
    S_SC_B  = 12'b001000000000,
    S_RD    = 12'b010000000000,
    S_EMIT  = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [3:0]        act_r, act_nxt;
  logic [31:0]       val_r, val_nxt;
  logic [CNT_W-1:0]  hops_r, hops_nxt, n_r, n_nxt, total_r, total_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [LINK_W-1:0] cur_r, cur_nxt, prev_r, prev_nxt, nxt_r, nxt_nxt;
  logic [LINK_W-1:0] list_head_r, list_head_nxt, free_head_r, free_head_nxt;
  logic [SLOT_W-1:0] s_r, s_nxt, slot_r, slot_nxt;
  logic              found_r, found_nxt;
  logic [1:0]        st_r, st_nxt;

  logic              out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [31:0]       out_element_r, out_element_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [CNT_W-1:0]  out_length_r, out_length_nxt;

  // node store
  logic [LINK_W-1:0] link_mem [CAPACITY];
  logic [31:0]       val_mem  [CAPACITY];
  logic [CAPACITY-1:0] link_vld_r;
  logic              lw_en, vw_en;
  logic [ADDR_W-1:0] lw_addr, rd_addr, rd_addr_r;
  logic [LINK_W-1:0] lw_data;
  logic [LINK_W-1:0] link_raw_r, link_q;
  logic [31:0]       val_q_r;
  logic              rd_vld_r;
  logic              out_free;

  assign rd_addr = cur_nxt[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (lw_en) begin
      link_mem[lw_addr] <= lw_data;
    end
    if (vw_en) begin
      val_mem[s_r[ADDR_W-1:0]] <= val_r;
    end
    link_raw_r <= link_mem[rd_addr];
    val_q_r    <= val_mem[rd_addr];
    rd_addr_r  <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_vld_r <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      rd_vld_r <= link_vld_r[rd_addr];
      if (lw_en) begin
        link_vld_r[lw_addr] <= 1'b1;
      end
    end
  end

  // unwritten entries read their reset chain: slot i links to i minus 1
  always_comb begin
    if (rd_vld_r) begin
      link_q = link_raw_r;
    end else if (rd_addr_r == '0) begin
      link_q = NIL;
    end else begin
      link_q = LINK_W'(rd_addr_r - 1'b1);
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt       = state_r;
    act_nxt         = act_r;
    val_nxt         = val_r;
    hops_nxt        = hops_r;
    n_nxt           = n_r;
    total_nxt       = total_r;
    count_nxt       = count_r;
    cur_nxt         = cur_r;
    prev_nxt        = prev_r;
    nxt_nxt         = nxt_r;
    list_head_nxt   = list_head_r;
    free_head_nxt   = free_head_r;
    s_nxt           = s_r;
    slot_nxt        = slot_r;
    found_nxt       = found_r;
    st_nxt          = st_r;
    lw_en           = 1'b0;
    vw_en           = 1'b0;
    lw_addr         = cur_r[ADDR_W-1:0];
    lw_data         = free_head_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_element_nxt = out_element_r;
    out_slot_nxt    = out_slot_r;
    out_length_nxt  = out_length_r;
    out_last_nxt    = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt  = in_action;
          val_nxt  = in_value;
          prev_nxt = NIL;
          n_nxt    = '0;
          slot_nxt = '0;
          st_nxt   = ST_OK;
          found_nxt = 1'b0;
          unique case (in_action)
            ACT_INS_END, ACT_INS_HEAD, ACT_INS_POS: begin
              if (free_head_r[LINK_W-1]) begin
                st_nxt    = ST_FULL;
                state_nxt = S_EMIT;
              end else begin
                s_nxt   = free_head_r[SLOT_W-1:0];
                cur_nxt = free_head_r;
                if (in_action == ACT_INS_END) begin
                  hops_nxt = CNT_W'(CAPACITY);
                end else if (in_action == ACT_INS_HEAD || in_position <= 7'd1) begin
                  hops_nxt = '0;
                end else begin
                  hops_nxt = in_position - 7'd1;
                end
                state_nxt = S_POP;
              end
            end
            ACT_DEL_END, ACT_DEL_HEAD, ACT_DEL_POS: begin
              cur_nxt = list_head_r;
              if (in_action == ACT_DEL_END) begin
                hops_nxt = count_r - 7'd1;
              end else if (in_action == ACT_DEL_HEAD) begin
                hops_nxt = '0;
              end else begin
                hops_nxt = in_position - 7'd1;
              end
              priority if (list_head_r[LINK_W-1]) begin
                st_nxt    = ST_EMPTY;
                state_nxt = S_EMIT;
              end else if (in_action == ACT_DEL_POS &&
                           (in_position == 7'd0 || in_position > count_r)) begin
                st_nxt    = ST_BADPOS;
                state_nxt = S_EMIT;
              end else begin
                state_nxt = S_WALK;
              end
            end
            ACT_DEL_ONE, ACT_DEL_ALL: begin
              cur_nxt   = list_head_r;
              state_nxt = S_SCAN;
            end
            ACT_READ: begin
              cur_nxt   = list_head_r;
              total_nxt = (count_r > CNT_W'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : count_r;
              if (count_r == '0 || list_head_r[LINK_W-1]) begin
                st_nxt    = ST_EMPTY;
                state_nxt = S_EMIT;
              end else begin
                state_nxt = S_RD;
              end
            end
            default: begin
              state_nxt = S_EMIT;
            end
          endcase
        end
      end
      S_POP: begin
        // link of the popped slot becomes the new free head
        free_head_nxt = link_q;
        cur_nxt       = list_head_r;
        state_nxt     = S_WALK;
      end
      S_WALK: begin
        if (!cur_r[LINK_W-1] && n_r < hops_r) begin
          prev_nxt = cur_r;
          cur_nxt  = link_q;
          n_nxt    = n_r + 7'd1;
        end else if (act_r == ACT_INS_END || act_r == ACT_INS_HEAD ||
                     act_r == ACT_INS_POS) begin
          state_nxt = S_INS_A;
        end else if (cur_r[LINK_W-1]) begin
          st_nxt    = ST_EMPTY;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_DEL_A;
        end
      end
      S_INS_A: begin
        // new node links to whatever followed prev
        lw_en     = 1'b1;
        vw_en     = 1'b1;
        lw_addr   = s_r[ADDR_W-1:0];
        lw_data   = cur_r;
        count_nxt = count_r + 7'd1;
        slot_nxt  = s_r;
        if (prev_r[LINK_W-1]) begin
          list_head_nxt = LINK_W'(s_r);
          state_nxt     = S_EMIT;
        end else begin
          state_nxt = S_INS_B;
        end
      end
      S_INS_B: begin
        lw_en     = 1'b1;
        lw_addr   = prev_r[ADDR_W-1:0];
        lw_data   = LINK_W'(s_r);
        state_nxt = S_EMIT;
      end
      S_DEL_A: begin
        if (prev_r[LINK_W-1]) begin
          list_head_nxt = link_q;
        end else begin
          lw_en   = 1'b1;
          lw_addr = prev_r[ADDR_W-1:0];
          lw_data = link_q;
        end
        state_nxt = S_DEL_B;
      end
      S_DEL_B: begin
        lw_en         = 1'b1;
        lw_addr       = cur_r[ADDR_W-1:0];
        lw_data       = free_head_r;
        free_head_nxt = cur_r;
        count_nxt     = count_r - 7'd1;
        slot_nxt      = cur_r[SLOT_W-1:0];
        state_nxt     = S_EMIT;
      end
      S_SCAN: begin
        if (cur_r[LINK_W-1] || n_r >= CNT_W'(CAPACITY)) begin
          st_nxt    = found_r ? ST_OK : ST_EMPTY;
          state_nxt = S_EMIT;
        end else if (val_q_r == val_r) begin
          nxt_nxt   = link_q;
          state_nxt = S_SC_A;
        end else begin
          prev_nxt = cur_r;
          cur_nxt  = link_q;
          n_nxt    = n_r + 7'd1;
        end
      end
      S_SC_A: begin
        if (prev_r[LINK_W-1]) begin
          list_head_nxt = nxt_r;
        end else begin
          lw_en   = 1'b1;
          lw_addr = prev_r[ADDR_W-1:0];
          lw_data = nxt_r;
        end
        state_nxt = S_SC_B;
      end
      S_SC_B: begin
        lw_en         = 1'b1;
        lw_addr       = cur_r[ADDR_W-1:0];
        lw_data       = free_head_r;
        free_head_nxt = cur_r;
        count_nxt     = count_r - 7'd1;
        slot_nxt      = cur_r[SLOT_W-1:0];
        found_nxt     = 1'b1;
        if (act_r == ACT_DEL_ONE) begin
          st_nxt    = ST_OK;
          state_nxt = S_EMIT;
        end else begin
          cur_nxt   = nxt_r;
          n_nxt     = n_r + 7'd1;
          state_nxt = S_SCAN;
        end
      end
      S_RD: begin
        if (cur_r[LINK_W-1]) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = ST_OK;
          out_element_nxt = val_q_r;
          out_slot_nxt    = cur_r[SLOT_W-1:0];
          out_length_nxt  = count_r;
          out_last_nxt    = (n_r + 7'd1 == total_r) || link_q[LINK_W-1];
          if (out_last_nxt) begin
            state_nxt = S_IDLE;
          end else begin
            cur_nxt = link_q;
            n_nxt   = n_r + 7'd1;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = st_r;
          out_element_nxt = '0;
          out_slot_nxt    = (st_r == ST_OK) ? slot_r : '0;
          out_length_nxt  = count_r;
          out_last_nxt    = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      list_head_r <= NIL;
      free_head_r <= LINK_W'(CAPACITY - 1);
      count_r     <= '0;
      out_valid_r <= 1'b0;
      cur_r       <= NIL;
    end else begin
      state_r     <= state_nxt;
      list_head_r <= list_head_nxt;
      free_head_r <= free_head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      cur_r       <= cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r         <= act_nxt;
    val_r         <= val_nxt;
    hops_r        <= hops_nxt;
    n_r           <= n_nxt;
    total_r       <= total_nxt;
    prev_r        <= prev_nxt;
    nxt_r         <= nxt_nxt;
    s_r           <= s_nxt;
    slot_r        <= slot_nxt;
    found_r       <= found_nxt;
    st_r          <= st_nxt;
    out_status_r  <= out_status_nxt;
    out_element_r <= out_element_nxt;
    out_slot_r    <= out_slot_nxt;
    out_length_r  <= out_length_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_element = out_element_r;
  assign out_slot    = out_slot_r;
  assign out_length  = out_length_r;
  assign out_last    = out_last_r;

endmodule
`default_nettype wire
